>>> hdl/hpt_pkg.sv
// Shared types, widths and register reset values for the homogeneous point transform.
package hpt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int REG_W     = 64;
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;
	// four products of 32x32 bits summed exactly
	localparam int ACC_W     = 2 * COORD_W + 2;
	// remainder and compare width in the divider: |num| << FRAC_BITS against |den| << 32
	localparam int CMP_W     = ACC_W + COORD_W + 1;

	localparam logic [REG_W-1:0] ONE_FIX = REG_W'(1) << FRAC_BITS;
	localparam logic [REG_W-1:0] ONE_HI  = ONE_FIX << COORD_W;

	// identity matrix, register 7 first
	localparam logic [NUM_REGS-1:0][REG_W-1:0] REG_RESET = {
		ONE_HI, {REG_W{1'b0}}, ONE_FIX, {REG_W{1'b0}},
		{REG_W{1'b0}}, ONE_HI, {REG_W{1'b0}}, ONE_FIX
	};

	localparam logic [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] NEG_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic [3:0][3:0][COORD_W-1:0] mat_t;

	typedef struct packed {
		logic valid;
		logic wzero;
	} ctl_t;

endpackage

>>> hdl/hpt_matmul.sv
// Three-stage matrix-vector product: multiply, pairwise add, final add.
module hpt_matmul
	import hpt_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [COORD_W-1:0]       point_x,
	input  logic [COORD_W-1:0]       point_y,
	input  logic [COORD_W-1:0]       point_z,
	input  mat_t                     mat,
	output logic                     out_valid,
	output acc_t                     acc [4]
);

	logic [COORD_W-1:0]        pt [3];
	logic signed [2*COORD_W-1:0] p_s1 [4][3];
	logic signed [COORD_W-1:0]   w_s1 [4];
	acc_t                      a_s2 [4];
	acc_t                      b_s2 [4];
	acc_t                      acc_s3 [4];
	logic                      v_s1, v_s2, v_s3;

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// products, sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 3; c++) begin
					p_s1[r][c] <= $signed(mat[r][c]) * $signed(pt[c]);
				end
				w_s1[r] <= $signed(mat[r][3]);
				a_s2[r] <= acc_t'(p_s1[r][0]) + acc_t'(p_s1[r][1]);
				// w column times 1.0 is a shift
				b_s2[r] <= acc_t'(p_s1[r][2]) + (acc_t'(w_s1[r]) <<< FRAC_BITS);
				acc_s3[r] <= a_s2[r] + b_s2[r];
			end
		end
	end

	assign out_valid = v_s3;
	assign acc = acc_s3;

endmodule

>>> hdl/hpt_divider.sv
// Pipelined restoring divider: one quotient bit per stage, truncation and saturation.
module hpt_divider
	import hpt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  ctl_t               ctl_in,
	input  acc_t               num,
	input  acc_t               den,
	output ctl_t               ctl_out,
	output logic [COORD_W-1:0] quot,
	output logic               sat
);

	logic [ACC_W-1:0]   nabs, dabs;
	logic [CMP_W-1:0]   nscaled, dscaled;

	ctl_t               ctl_s [COORD_W+1];
	logic [CMP_W-1:0]   rem_s [COORD_W+1];
	logic [ACC_W-1:0]   d_s   [COORD_W+1];
	logic [COORD_W-1:0] q_s   [COORD_W+1];
	logic               neg_s [COORD_W+1];
	logic               ovf_s [COORD_W+1];

	ctl_t               ctl_o_q;
	logic [COORD_W-1:0] quot_q;
	logic               sat_q;

	// magnitudes and overflow check (quotient of 2^32 or more)
	always_comb begin
		nabs    = num[ACC_W-1] ? ACC_W'(-num) : num;
		dabs    = den[ACC_W-1] ? ACC_W'(-den) : den;
		nscaled = CMP_W'(nabs) << FRAC_BITS;
		dscaled = CMP_W'(dabs) << COORD_W;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= nscaled;
			d_s[0]   <= dabs;
			q_s[0]   <= '0;
			neg_s[0] <= num[ACC_W-1] ^ den[ACC_W-1];
			ovf_s[0] <= nscaled >= dscaled;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar i = 0; i < COORD_W; i++) begin : g_step
		localparam int K = COORD_W - 1 - i;
		logic [CMP_W:0] trial;

		assign trial = {1'b0, rem_s[i]} - {1'b0, CMP_W'(d_s[i]) << K};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else if (en) begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= trial[CMP_W] ? rem_s[i] : trial[CMP_W-1:0];
				q_s[i+1]   <= q_s[i] | (trial[CMP_W] ? '0 : (COORD_W'(1) << K));
				d_s[i+1]   <= d_s[i];
				neg_s[i+1] <= neg_s[i];
				ovf_s[i+1] <= ovf_s[i];
			end
		end
	end

	// sign, clamp, zero-w override
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o_q <= '0;
		end else if (en) begin
			ctl_o_q <= ctl_s[COORD_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_s[COORD_W].wzero) begin
				quot_q <= '0;
				sat_q  <= 1'b0;
			end else if (neg_s[COORD_W]) begin
				if (ovf_s[COORD_W] || q_s[COORD_W] > NEG_MIN) begin
					quot_q <= NEG_MIN;
					sat_q  <= 1'b1;
				end else begin
					quot_q <= COORD_W'(-q_s[COORD_W]);
					sat_q  <= 1'b0;
				end
			end else begin
				if (ovf_s[COORD_W] || q_s[COORD_W][COORD_W-1]) begin
					quot_q <= POS_MAX;
					sat_q  <= 1'b1;
				end else begin
					quot_q <= q_s[COORD_W];
					sat_q  <= 1'b0;
				end
			end
		end
	end

	assign ctl_out = ctl_o_q;
	assign quot    = quot_q;
	assign sat     = sat_q;

endmodule

>>> hdl/homogeneous_point_transform.sv
// Top level: matrix registers, matrix product and three perspective dividers.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: point_x, point_y, point_z
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: result_x, result_y, result_z
//                                              tuser: w_was_zero, saturated
//  cfg       in   cfg_we                       cfg_index, cfg_data (two entries of a row)
//
// One point per cycle while m_axis is not stalled. The matrix product multiplies, adds
// in pairs and adds again; the divider has setup, one stage per quotient bit, sign and clamp.
// Reset sets the matrix to identity and clears all valid bits.
// A stall on m_axis holds the whole pipeline; s_axis_tready follows it.
module homogeneous_point_transform
	import hpt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [3*COORD_W-1:0]  s_axis_tdata,  // point_x, point_y, point_z
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [3*COORD_W-1:0]  m_axis_tdata,  // result_x, result_y, result_z
	output logic [1:0]            m_axis_tuser,  // w_was_zero, saturated
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [REG_W-1:0]      cfg_data
);

	logic [NUM_REGS-1:0][REG_W-1:0] regs_q;
	mat_t               mat;
	logic               en;
	logic               mm_valid;
	acc_t               acc [4];
	ctl_t               div_ctl;
	ctl_t               ctl_o [3];
	logic [COORD_W-1:0] quot [3];
	logic               sat [3];

	// matrix registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= REG_RESET;
		end else if (cfg_we) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	// unpack: even column in the low half, odd column in the high half
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				mat[r][c] = regs_q[r*2 + c/2][(c%2)*COORD_W +: COORD_W];
			end
		end
	end

	// global pipeline advance
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	hpt_matmul u_matmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.point_x   (s_axis_tdata[0 +: COORD_W]),
		.point_y   (s_axis_tdata[COORD_W +: COORD_W]),
		.point_z   (s_axis_tdata[2*COORD_W +: COORD_W]),
		.mat       (mat),
		.out_valid (mm_valid),
		.acc       (acc)
	);

	assign div_ctl.valid = mm_valid;
	assign div_ctl.wzero = acc[3] == '0;

	for (genvar i = 0; i < 3; i++) begin : g_div
		hpt_divider u_div (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_in  (div_ctl),
			.num     (acc[i]),
			.den     (acc[3]),
			.ctl_out (ctl_o[i]),
			.quot    (quot[i]),
			.sat     (sat[i])
		);
	end

	assign m_axis_tvalid   = ctl_o[0].valid;
	assign m_axis_tdata    = {quot[2], quot[1], quot[0]};
	assign m_axis_tuser[0] = ctl_o[0].wzero;
	assign m_axis_tuser[1] = sat[0] | sat[1] | sat[2];

	// zero w gives zero coordinates and no clamp
	a_wzero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
		else $error("zero w result not cleared");

	// a clamp shows a limit value in some coordinate
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |->
		quot[0] == POS_MAX || quot[0] == NEG_MIN || quot[1] == POS_MAX ||
		quot[1] == NEG_MIN || quot[2] == POS_MAX || quot[2] == NEG_MIN)
		else $error("saturation flag without a limit value");

	// the three dividers stay in step
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_o[0] == ctl_o[1] && ctl_o[1] == ctl_o[2])
		else $error("divider lanes out of step");

endmodule

>>> tb/tb_homogeneous_point_transform.sv
// Testbench for the homogeneous point transform: matrix product and perspective divide.
`timescale 1ns / 1ps

module tb_homogeneous_point_transform;
	import hpt_pkg::*;

	typedef struct packed {
		logic [COORD_W-1:0] z;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} point_t;

	typedef struct {
		logic [COORD_W-1:0] rx;
		logic [COORD_W-1:0] ry;
		logic [COORD_W-1:0] rz;
		logic               wzero;
		logic               sat;
	} proj_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [3*COORD_W-1:0] s_axis_tdata;   // point_x, point_y, point_z
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [3*COORD_W-1:0] m_axis_tdata;   // result_x, result_y, result_z
	logic [1:0]           m_axis_tuser;   // w_was_zero, saturated
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;

	logic [REG_W-1:0] matrix_regs [NUM_REGS];
	proj_t            pending_points [$];
	int               error_count;
	bit               idle_enable;
	bit               hold_off;

	homogeneous_point_transform u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// matrix entry as signed value
	function automatic logic signed [COORD_W-1:0] entry(int r, int c);
		logic [REG_W-1:0] rv;
		rv = matrix_regs[r * 2 + c / 2];
		return (c % 2) ? rv[63:32] : rv[31:0];
	endfunction

	// truncating divide of num << FRAC_BITS by den, clamped to 32 bits
	function automatic logic [COORD_W-1:0] divide_clamp(logic signed [127:0] num,
			logic signed [127:0] den, inout logic sat);
		logic signed [127:0] q;
		q = (num <<< FRAC_BITS) / den;
		if (q > 128'sh7FFFFFFF) begin
			sat = 1'b1;
			return POS_MAX;
		end
		if (q < -128'sh80000000) begin
			sat = 1'b1;
			return NEG_MIN;
		end
		return q[31:0];
	endfunction

	function automatic proj_t project_point(point_t p);
		logic signed [127:0] acc [4];
		logic signed [127:0] v [4];
		proj_t res;
		logic sat;
		v[0] = $signed(p.x);
		v[1] = $signed(p.y);
		v[2] = $signed(p.z);
		v[3] = 128'sd1 <<< FRAC_BITS;
		for (int r = 0; r < 4; r++) begin
			acc[r] = 0;
			for (int c = 0; c < 4; c++)
				acc[r] += 128'(entry(r, c)) * v[c];
		end
		res = '{default: '0};
		sat = 1'b0;
		if (acc[3] == 0) begin
			res.wzero = 1'b1;
			return res;
		end
		res.rx = divide_clamp(acc[0], acc[3], sat);
		res.ry = divide_clamp(acc[1], acc[3], sat);
		res.rz = divide_clamp(acc[2], acc[3], sat);
		res.sat = sat;
		return res;
	endfunction

	// random source gap
	task automatic source_gap();
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// tvalid stays high after a transfer so the next item can follow directly
	task automatic send_point(point_t p);
		source_gap();
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= p;
		pending_points.push_back(project_point(p));
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// stop offering, wait for pipeline drain, then the latency margin
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [REG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx[REG_IDX_W-1:0];
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		matrix_regs[idx] = val;
		@(posedge clk);
	endtask

	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? POS_MAX : NEG_MIN;
			1: return $urandom_range(0, 3) - 2;
			2: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 20'sh80000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] rand_entry();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 32'(ONE_FIX);
			2: return 32'($signed($urandom_range(0, 18'h3FFFF)) - 18'sh20000);
			default: return $urandom;
		endcase
	endfunction

	task automatic load_random_matrix();
		for (int i = 0; i < NUM_REGS; i++)
			write_reg(i, {rand_entry(), rand_entry()});
	endtask

	task automatic test_identity_extremes();
		point_t pts [8];
		pts[0] = '{z: 0, y: 0, x: 0};
		pts[1] = '{z: POS_MAX, y: NEG_MIN, x: POS_MAX};
		pts[2] = '{z: NEG_MIN, y: POS_MAX, x: NEG_MIN};
		pts[3] = '{z: 32'hFFFFFFFF, y: 32'h1, x: 32'h10000};
		pts[4] = '{z: 32'hAAAAAAAA, y: 32'h55555555, x: 32'hFFFF0000};
		pts[5] = '{z: 32'h55555555, y: 32'hAAAAAAAA, x: 32'h0000FFFF};
		pts[6] = '{z: 32'h12345678, y: 32'h87654321, x: 32'hDEADBEEF};
		pts[7] = '{z: 32'h80000001, y: 32'h7FFFFFFE, x: 32'h00008000};
		foreach (pts[i]) send_point(pts[i]);
		drain();
	endtask

	// w from z: zero w, saturation, and exact negative minimum
	task automatic test_perspective_cases();
		for (int i = 0; i < NUM_REGS; i++) write_reg(i, 0);
		write_reg(0, {32'h0, 32'h10000});
		write_reg(2, {32'h10000, 32'h0});
		write_reg(5, {32'h0, 32'h10000});
		write_reg(7, {32'h0, 32'h10000});   // w = z
		send_point('{z: 0, y: 32'h10000, x: 32'h10000});
		send_point('{z: 32'h1, y: POS_MAX, x: NEG_MIN});
		send_point('{z: 32'hFFFFFFFF, y: POS_MAX, x: NEG_MIN});
		send_point('{z: 32'h10000, y: NEG_MIN, x: POS_MAX});
		send_point('{z: 32'h20000, y: NEG_MIN, x: 32'h8000_0000});
		send_point('{z: 32'h8000, y: 32'hC000_0000, x: 32'h4000_0000});
		send_point('{z: 32'hFFFF0000, y: 32'h30000, x: 32'hFFFD0000});
		drain();
		// w from the whole bottom row; max and min entries
		write_reg(7, {POS_MAX, NEG_MIN});
		write_reg(6, {NEG_MIN, POS_MAX});
		write_reg(1, {POS_MAX, NEG_MIN});
		send_point('{z: POS_MAX, y: NEG_MIN, x: POS_MAX});
		send_point('{z: NEG_MIN, y: NEG_MIN, x: NEG_MIN});
		send_point('{z: 0, y: 0, x: 0});
		drain();
	endtask

	task automatic test_random_points();
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 5) idle_enable = 1'b0;
			if (phase > 0) load_random_matrix();
			for (int n = 0; n < 120; n++) begin
				point_t p;
				p.x = rand_coord();
				p.y = rand_coord();
				p.z = rand_coord();
				send_point(p);
			end
			drain();
		end
	endtask

	// receiver stall while the source keeps offering
	task automatic test_backpressure();
		hold_off = 1'b1;
		for (int n = 0; n < 60; n++) begin
			point_t p;
			p.x = $urandom;
			p.y = $urandom;
			p.z = $urandom;
			send_point(p);
		end
		drain();
	endtask

	// sink readiness
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_axis_tready <= 1'b0;
				repeat (150) @(posedge clk);
				hold_off = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (idle_enable && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_points.size() == 0) begin
				$error("unexpected transfer: tdata %h", m_axis_tdata);
				error_count++;
			end else begin
				proj_t e;
				e = pending_points.pop_front();
				if (m_axis_tdata[31:0] !== e.rx) begin
					$error("result_x exp %h got %h", e.rx, m_axis_tdata[31:0]);
					error_count++;
				end
				if (m_axis_tdata[63:32] !== e.ry) begin
					$error("result_y exp %h got %h", e.ry, m_axis_tdata[63:32]);
					error_count++;
				end
				if (m_axis_tdata[95:64] !== e.rz) begin
					$error("result_z exp %h got %h", e.rz, m_axis_tdata[95:64]);
					error_count++;
				end
				if (m_axis_tuser[0] !== e.wzero) begin
					$error("w_was_zero exp %b got %b", e.wzero, m_axis_tuser[0]);
					error_count++;
				end
				if (m_axis_tuser[1] !== e.sat) begin
					$error("saturated exp %b got %b", e.sat, m_axis_tuser[1]);
					error_count++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		error_count   = 0;
		idle_enable   = 1'b1;
		hold_off      = 1'b0;
		for (int i = 0; i < NUM_REGS; i++) matrix_regs[i] = REG_RESET[i];
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_identity_extremes();
		test_perspective_cases();
		test_backpressure();
		test_random_points();
		if (pending_points.size() != 0) error_count++;
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
